FILE: hw/rtl/pavg_pkg.sv
// Shared types, widths and helpers for the polygon area and vertex gradient unit.
`default_nettype none

package pavg_pkg;

  // Field widths
  localparam int COORD_W     = 16;
  localparam int IDX_W       = 10;
  localparam int GRAD_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int CROSS_W     = PROD_W + 2;
  localparam int AREA_W      = 43;
  localparam int ABS_W       = AREA_W - 1;

  // Stream widths
  localparam int IN_TDATA_W    = 2 * COORD_W;
  localparam int OUT_FIELDS_W  = IDX_W + 2 * GRAD_W + AREA_W + ABS_W + 1;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  // Defaults
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int QUEUE_DEPTH      = 8;

  typedef enum logic {
    KIND_GRAD = 1'b0,
    KIND_AREA = 1'b1
  } kind_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } grad_t;

  // Everything one vertex emits besides the area figures
  typedef struct packed {
    logic        last;
    logic [1:0]  g_cnt;
    grad_t [2:0] grads;
  } emit_t;

  typedef struct packed {
    logic                     push;
    logic                     has_prev;
    logic                     closes3;
    emit_t                    em;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
    logic signed [PROD_W-1:0] p3;
    logic signed [PROD_W-1:0] p4;
  } front_rec_t;

  typedef struct packed {
    logic                      push;
    logic                      closes3;
    emit_t                     em;
    logic signed [CROSS_W-1:0] e;
  } cross_rec_t;

  typedef struct packed {
    logic              push;
    emit_t             em;
    logic [AREA_W-1:0] area;
  } sum_rec_t;

  typedef struct packed {
    emit_t             em;
    logic [AREA_W-1:0] area;
    logic [ABS_W-1:0]  mag;
    logic              neg;
  } entry_t;

  // Signed difference of two coordinates, one bit wider
  function automatic logic signed [GRAD_W-1:0] coord_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

  // Sign-extend a product to the cross-term width
  function automatic logic signed [CROSS_W-1:0] prod_ext(
    input logic signed [PROD_W-1:0] p
  );
    return {{(CROSS_W - PROD_W){p[PROD_W-1]}}, p};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/polygon_area_vertex_gradient_unit.sv
// Path: a vertex passes the input, cross, sum and magnitude registers into the queue.
// Throughput: one vertex per cycle while a queue slot is free; each vertex gives
//   at most one gradient except the closing one, which gives up to three gradients
//   and the area item, one per cycle with m_axis_tready high, via the 8-entry queue.
// Reset: synchronous, clears vertex history, accumulator, queue and credits at once.
`default_nettype none

module polygon_area_vertex_gradient_unit #(
  parameter int MAX_VERTICES = pavg_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // tdata: vertex_x [15:0], vertex_y [31:16]; tlast: closes_polygon
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [pavg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                             s_axis_tlast,
  // tdata: vertex_index, twice_grad_x, twice_grad_y, twice_signed_area,
  //        twice_abs_area, area_negative, zero pad; tuser: result_kind;
  //        tlast: last_of_run
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [pavg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [0:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast
);
  import pavg_pkg::*;

  logic       a_valid;
  front_rec_t a_rec;
  logic       d_valid;
  entry_t     d_entry;
  logic       item_done;

  pavg_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .DEPTH        (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .item_done     (item_done),
    .a_valid       (a_valid),
    .a_rec         (a_rec)
  );

  pavg_area u_area (
    .clk     (clk),
    .rst     (rst),
    .a_valid (a_valid),
    .a_rec   (a_rec),
    .d_valid (d_valid),
    .d_entry (d_entry)
  );

  pavg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk           (clk),
    .rst           (rst),
    .wr_valid      (d_valid),
    .wr_entry      (d_entry),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .item_done     (item_done)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/pavg_front.sv
// Input side: vertex history, run control, credit count, products and gradients.
`default_nettype none

module pavg_front #(
  parameter int MAX_VERTICES = pavg_pkg::MAX_VERTICES_DEF,
  parameter int DEPTH        = pavg_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [pavg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                             s_axis_tlast,
  input  wire logic                             item_done,
  output logic                                  a_valid,
  output pavg_pkg::front_rec_t                  a_rec
);
  import pavg_pkg::*;

  localparam int CNT_W  = $clog2(MAX_VERTICES);
  localparam int CRED_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]          cnt;
  logic [CRED_W-1:0]         credits;
  logic signed [COORD_W-1:0] first_x, first_y, second_x, second_y;
  logic signed [COORD_W-1:0] older_x, older_y, prior_x, prior_y;

  logic                      acc;
  logic                      last_eff;
  logic                      many;
  logic signed [COORD_W-1:0] xs, ys;
  logic [31:0]               n_w, nm1_w;
  front_rec_t                rec_next;

  assign xs       = s_axis_tdata[COORD_W-1:0];
  assign ys       = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign last_eff = s_axis_tlast || (cnt == CNT_W'(MAX_VERTICES - 1));
  assign many     = (cnt > CNT_W'(1));
  assign n_w      = 32'(cnt);
  assign nm1_w    = 32'(cnt - CNT_W'(1));

  // Hold input while every queue slot is promised to an item in flight
  assign s_axis_tready = (credits < CRED_W'(DEPTH));
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Build the record for this vertex
  always_comb begin
    rec_next          = '0;
    rec_next.has_prev = (cnt != '0);
    rec_next.closes3  = last_eff && many;
    rec_next.push     = many || last_eff;
    rec_next.em.last  = last_eff;
    rec_next.p1       = prior_x * ys;
    rec_next.p2       = xs * prior_y;
    rec_next.p3       = xs * first_y;
    rec_next.p4       = first_x * ys;
    if (many) begin
      rec_next.em.grads[0].idx = nm1_w[IDX_W-1:0];
      rec_next.em.grads[0].gx  = coord_diff(ys, older_y);
      rec_next.em.grads[0].gy  = coord_diff(older_x, xs);
      if (last_eff) begin
        rec_next.em.g_cnt        = 2'd3;
        rec_next.em.grads[1].idx = '0;
        rec_next.em.grads[1].gx  = coord_diff(second_y, ys);
        rec_next.em.grads[1].gy  = coord_diff(xs, second_x);
        rec_next.em.grads[2].idx = n_w[IDX_W-1:0];
        rec_next.em.grads[2].gx  = coord_diff(first_y, prior_y);
        rec_next.em.grads[2].gy  = coord_diff(prior_x, first_x);
      end else begin
        rec_next.em.g_cnt = 2'd1;
      end
    end else if (last_eff) begin
      // Short run: zero gradients for vertex 0 and, if present, vertex 1
      rec_next.em.grads[1].idx = IDX_W'(1);
      rec_next.em.g_cnt        = (cnt == '0) ? 2'd1 : 2'd2;
    end
  end

  // Advance vertex history and run count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      first_x  <= '0;
      first_y  <= '0;
      second_x <= '0;
      second_y <= '0;
      older_x  <= '0;
      older_y  <= '0;
      prior_x  <= '0;
      prior_y  <= '0;
    end else if (acc) begin
      if (last_eff) begin
        cnt      <= '0;
        first_x  <= '0;
        first_y  <= '0;
        second_x <= '0;
        second_y <= '0;
        older_x  <= '0;
        older_y  <= '0;
        prior_x  <= '0;
        prior_y  <= '0;
      end else begin
        if (cnt == '0) begin
          first_x <= xs;
          first_y <= ys;
        end
        if (cnt == CNT_W'(1)) begin
          second_x <= xs;
          second_y <= ys;
        end
        older_x <= prior_x;
        older_y <= prior_y;
        prior_x <= xs;
        prior_y <= ys;
        cnt     <= cnt + CNT_W'(1);
      end
    end
  end

  // Track items that own or will own a queue slot
  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      priority case ({acc && rec_next.push, item_done})
        2'b10:   credits <= credits + CRED_W'(1);
        2'b01:   credits <= credits - CRED_W'(1);
        default: credits <= credits;
      endcase
    end
  end

  // Input register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_rec <= rec_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pavg_area.sv
// Cross-term sum, running area accumulator and magnitude stage.
`default_nettype none

module pavg_area (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 a_valid,
  input  wire pavg_pkg::front_rec_t a_rec,
  output logic                      d_valid,
  output pavg_pkg::entry_t          d_entry
);
  import pavg_pkg::*;

  logic              b_valid;
  cross_rec_t        b_rec;
  logic              c_valid;
  sum_rec_t          c_rec;
  logic [AREA_W-1:0] cross_sum;

  logic signed [CROSS_W-1:0] d1, d2;
  logic [AREA_W-1:0]         sum;
  logic [AREA_W-1:0]         neg_area;

  // Combine the products of this vertex into one cross term
  assign d1 = a_rec.has_prev ? (prod_ext(a_rec.p1) - prod_ext(a_rec.p2)) : '0;
  assign d2 = a_rec.closes3  ? (prod_ext(a_rec.p3) - prod_ext(a_rec.p4)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      b_rec.push    <= a_rec.push;
      b_rec.closes3 <= a_rec.closes3;
      b_rec.em      <= a_rec.em;
      b_rec.e       <= d1 + d2;
    end
  end

  // Accumulate; drop the sum at the end of each run
  assign sum = cross_sum + {{(AREA_W - CROSS_W){b_rec.e[CROSS_W-1]}}, b_rec.e};

  always_ff @(posedge clk) begin
    if (rst) begin
      cross_sum <= '0;
      c_valid   <= 1'b0;
    end else begin
      c_valid <= b_valid && b_rec.push;
      if (b_valid) begin
        cross_sum <= b_rec.em.last ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      c_rec.push <= b_rec.push;
      c_rec.em   <= b_rec.em;
      c_rec.area <= b_rec.closes3 ? sum : '0;
    end
  end

  // Magnitude and sign of the area
  assign neg_area = '0 - c_rec.area;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid) begin
      d_entry.em   <= c_rec.em;
      d_entry.area <= c_rec.area;
      d_entry.neg  <= c_rec.area[AREA_W-1];
      d_entry.mag  <= c_rec.area[AREA_W-1] ? neg_area[ABS_W-1:0] : c_rec.area[ABS_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pavg_queue.sv
// Result queue: one entry per vertex that emits results, unrolled into single result transfers.
`default_nettype none

module pavg_queue #(
  parameter int DEPTH = pavg_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_valid,
  input  wire pavg_pkg::entry_t                 wr_entry,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [pavg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [0:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast,
  output logic                                  item_done
);
  import pavg_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [OCC_W-1:0]   occ;
  logic [1:0]         sub;

  entry_t             head;
  grad_t              g;
  logic               is_grad;
  logic               xfer;
  logic               pop;

  assign head    = slots[rd_ptr];
  assign is_grad = ({1'b0, sub} < {1'b0, head.em.g_cnt});
  assign m_axis_tvalid = (occ != '0);
  assign xfer    = m_axis_tvalid && m_axis_tready;
  // A run's closing entry ends on its area item, any other entry after one gradient
  assign pop       = xfer && (!is_grad || !head.em.last);
  assign item_done = pop;

  // Pick the gradient slot for the current step
  always_comb begin
    unique case (sub)
      2'd0:    g = head.em.grads[0];
      2'd1:    g = head.em.grads[1];
      2'd2:    g = head.em.grads[2];
      default: g = '0;
    endcase
  end

  // Drive the result transfer
  always_comb begin
    m_axis_tuser = is_grad ? KIND_GRAD : KIND_AREA;
    m_axis_tlast = !is_grad;
    if (is_grad) begin
      m_axis_tdata = {{OUT_PAD_W{1'b0}}, 1'b0, {ABS_W{1'b0}}, {AREA_W{1'b0}},
                      g.gy, g.gx, g.idx};
    end else begin
      m_axis_tdata = {{OUT_PAD_W{1'b0}}, head.neg, head.mag, head.area,
                      {GRAD_W{1'b0}}, {GRAD_W{1'b0}}, {IDX_W{1'b0}}};
    end
  end

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (wr_valid) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers, occupancy and step within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
      sub    <= '0;
    end else begin
      if (wr_valid) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
        sub    <= '0;
      end else if (xfer) begin
        sub <= sub + 2'd1;
      end
      priority case ({wr_valid, pop})
        2'b10:   occ <= occ + OCC_W'(1);
        2'b01:   occ <= occ - OCC_W'(1);
        default: occ <= occ;
      endcase
    end
  end

endmodule

`default_nettype wire
